// ===== rtl/iff_form_chunk_scanner_defines.svh =====
// ----------------------------------------------------------------------------
// IFF form chunk scanner assertion macros
// Shared assertion forms for the scanner's checker.
// ----------------------------------------------------------------------------
`ifndef IFF_FORM_CHUNK_SCANNER_DEFINES_SVH
`define IFF_FORM_CHUNK_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IFCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IFCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ifcs_pkg.sv =====
// ----------------------------------------------------------------------------
// IFF form chunk scanner package
// Types and constants shared by the scanner and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifcs_pkg;

    localparam logic [31:0] TAG_FORM        = 32'h464F_524D;
    localparam int          FORM_HDR_BYTES  = 12;
    localparam int          CHUNK_HDR_BYTES = 8;
    localparam logic [31:0] POS_TAG_END     = 32'd3;
    localparam logic [31:0] POS_SIZE_END    = 32'd7;
    localparam logic [31:0] POS_TYPE_END    = 32'd11;

    localparam logic [1:0] CFG_TARGET_TAG  = 2'd0;
    localparam logic [1:0] CFG_FORM_OFFSET = 2'd1;
    localparam logic [1:0] CFG_DATA_LENGTH = 2'd2;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_MATCH    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_NOT_FORM = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_FORM_TAG  = 3'd0,
        PH_FORM_SIZE = 3'd1,
        PH_FORM_TYPE = 3'd2,
        PH_HEADER    = 3'd3,
        PH_SKIP      = 3'd4
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] next_offset;
        logic [31:0] chunk_size;
        logic [31:0] chunk_data_offset;
        logic        last_of_run;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/iff_form_chunk_scanner.sv =====
// ----------------------------------------------------------------------------
// IFF form chunk scanner
// Walks an IFF form one byte per beat and reports every chunk with the
// target tag, then a complete or not-a-form result.
//
//   Channel  Direction  Beat contents
//   s_       in         tdata[7:0] data_byte, tlast last_byte
//   m_       out        tdata[95:0] offset/size/next, tuser kind, tlast
//   cfg_     in         register write, index and 32-bit data
//
// One byte is taken per cycle while s_tready is high; a beat's results enter
// a four-entry result queue in the same cycle the beat is accepted. s_tready
// drops only while the queue has fewer than two free entries. Reset is
// synchronous and clears scan state, registers and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iff_form_chunk_scanner
    import ifcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [31:0] offset, [63:32] size, [95:64] next
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic [31:0] target_tag_reg, target_tag_next;
    logic [31:0] form_offset_reg, form_offset_next;
    logic [31:0] data_length_reg, data_length_next;

    logic [31:0] byte_pos_reg, byte_pos_next;
    logic [32:0] abs_reg, abs_next;
    phase_t      phase_reg, phase_next, phase_step;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] fe_reg, fe_next;
    logic [32:0] skip_reg, skip_next;
    logic        done_reg, done_next, done_step;

    result_t                fifo_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0]   count_reg;

    logic        in_fire, pop;
    logic [63:0] shifted;
    logic [31:0] csize, csize_cl, fe_decl, fe_new;
    logic [33:0] cdata, sum, sum_p8, fe34;
    logic [34:0] next_off;
    logic        clamp, pad_raw, pad, walk_end, form_bad, first_fits;
    logic [32:0] skip_dec, skip_new;
    logic        skip_zero;

    logic        match_hit, end_hit, last_hit;
    kind_t       end_kind, last_kind;
    result_t     res_match, res_end, slot0, slot1;
    logic [1:0]  push_n;

    assign in_fire  = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = count_reg <= RES_CNT_W'(RES_DEPTH - 2);

    assign shifted  = {shift_reg[55:0], s_tdata};
    assign csize    = shifted[31:0];
    assign fe34     = {2'b00, fe_reg};
    assign cdata    = {1'b0, abs_reg} + 34'd1;
    assign sum      = cdata + {2'b00, csize};
    assign clamp    = sum > fe34;
    assign csize_cl = clamp ? ((fe34 > cdata) ? 32'(fe34 - cdata) : 32'd0) : csize;
    assign pad_raw  = csize[0];
    assign pad      = csize_cl[0];
    assign sum_p8   = sum + 34'(CHUNK_HDR_BYTES) + {33'd0, pad_raw};
    assign walk_end = clamp || (sum_p8 > fe34);
    assign next_off = {1'b0, cdata} + {3'b000, csize_cl} + {34'd0, pad};
    assign skip_new = {1'b0, csize_cl} + {32'd0, pad};
    assign skip_dec = (skip_reg == 33'd0) ? 33'd0 : skip_reg - 33'd1;
    assign skip_zero = skip_dec == 33'd0;

    assign form_bad = (csize != TAG_FORM)
        || (({1'b0, form_offset_reg} + 33'(FORM_HDR_BYTES)) > {1'b0, data_length_reg});
    assign fe_decl  = form_offset_reg + 32'(CHUNK_HDR_BYTES) + csize;
    assign fe_new   = (fe_decl > data_length_reg) ? data_length_reg : fe_decl;
    assign first_fits = ({2'b00, form_offset_reg} + 34'(FORM_HDR_BYTES + CHUNK_HDR_BYTES))
        <= fe34;

    always_comb begin
        target_tag_next  = target_tag_reg;
        form_offset_next = form_offset_reg;
        data_length_next = data_length_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET_TAG:  target_tag_next  = cfg_wdata;
                CFG_FORM_OFFSET: form_offset_next = cfg_wdata;
                CFG_DATA_LENGTH: data_length_next = cfg_wdata;
                default: ;
            endcase
        end

        byte_pos_next = byte_pos_reg;
        shift_next    = shift_reg;
        fe_next       = fe_reg;
        skip_next     = skip_reg;
        phase_step    = phase_reg;
        done_step     = done_reg;
        if (in_fire && !done_reg) begin
            shift_next    = shifted;
            byte_pos_next = byte_pos_reg + 32'd1;
            case (phase_reg)
                PH_FORM_TAG: begin
                    if (byte_pos_reg == POS_TAG_END) begin
                        if (form_bad) begin
                            done_step = 1'b1;
                        end else begin
                            phase_step = PH_FORM_SIZE;
                        end
                    end
                end
                PH_FORM_SIZE: begin
                    if (byte_pos_reg == POS_SIZE_END) begin
                        fe_next    = fe_new;
                        phase_step = PH_FORM_TYPE;
                    end
                end
                PH_FORM_TYPE: begin
                    if (byte_pos_reg == POS_TYPE_END) begin
                        if (!first_fits) begin
                            done_step = 1'b1;
                        end else begin
                            phase_step = PH_HEADER;
                            skip_next  = 33'(CHUNK_HDR_BYTES);
                        end
                    end
                end
                PH_HEADER: begin
                    skip_next = skip_dec;
                    if (skip_zero) begin
                        if (walk_end) begin
                            done_step = 1'b1;
                        end else if (csize_cl == 32'd0) begin
                            skip_next = 33'(CHUNK_HDR_BYTES);
                        end else begin
                            skip_next  = skip_new;
                            phase_step = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_zero) begin
                        phase_step = PH_HEADER;
                        skip_next  = 33'(CHUNK_HDR_BYTES);
                    end
                end
                default: begin
                    done_step = 1'b1;
                end
            endcase
        end

        phase_next = phase_step;
        done_next  = done_step;
        if (in_fire && s_tlast) begin
            byte_pos_next = 32'd0;
            shift_next    = 64'd0;
            fe_next       = 32'd0;
            skip_next     = 33'd0;
            phase_next    = PH_FORM_TAG;
            done_next     = 1'b0;
        end

        abs_next = {1'b0, form_offset_next} + {1'b0, byte_pos_next};
    end

    always_comb begin
        match_hit = in_fire && !done_reg && (phase_reg == PH_HEADER) && skip_zero
            && (shifted[63:32] == target_tag_reg);
        end_hit = in_fire && !done_reg && (
            ((phase_reg == PH_FORM_TAG) && (byte_pos_reg == POS_TAG_END) && form_bad)
            || ((phase_reg == PH_FORM_TYPE) && (byte_pos_reg == POS_TYPE_END) && !first_fits)
            || ((phase_reg == PH_HEADER) && skip_zero && walk_end));
        end_kind  = (phase_reg == PH_FORM_TAG) ? KIND_NOT_FORM : KIND_COMPLETE;
        last_hit  = in_fire && s_tlast && !done_step;
        last_kind = (phase_step < PH_HEADER) ? KIND_NOT_FORM : KIND_COMPLETE;

        res_match.kind              = KIND_MATCH;
        res_match.chunk_data_offset = cdata[31:0];
        res_match.chunk_size        = csize_cl;
        res_match.next_offset       = next_off[31:0];
        res_match.last_of_run       = !(end_hit || last_hit);

        res_end.kind              = end_hit ? end_kind : last_kind;
        res_end.chunk_data_offset = 32'd0;
        res_end.chunk_size        = 32'd0;
        res_end.next_offset       = 32'd0;
        res_end.last_of_run       = 1'b1;

        slot0  = match_hit ? res_match : res_end;
        slot1  = res_end;
        push_n = {1'b0, match_hit} + {1'b0, end_hit || last_hit};
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {fifo_mem[rd_ptr_reg].next_offset,
                       fifo_mem[rd_ptr_reg].chunk_size,
                       fifo_mem[rd_ptr_reg].chunk_data_offset};
    assign m_tuser  = fifo_mem[rd_ptr_reg].kind;
    assign m_tlast  = fifo_mem[rd_ptr_reg].last_of_run;

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + RES_PTR_W'(1)] <= slot1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_tag_reg  <= '0;
            form_offset_reg <= '0;
            data_length_reg <= '0;
            byte_pos_reg    <= '0;
            abs_reg         <= '0;
            phase_reg       <= PH_FORM_TAG;
            shift_reg       <= '0;
            fe_reg          <= '0;
            skip_reg        <= '0;
            done_reg        <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            target_tag_reg  <= target_tag_next;
            form_offset_reg <= form_offset_next;
            data_length_reg <= data_length_next;
            byte_pos_reg    <= byte_pos_next;
            abs_reg         <= abs_next;
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            fe_reg          <= fe_next;
            skip_reg        <= skip_next;
            done_reg        <= done_next;
            wr_ptr_reg      <= wr_ptr_reg + RES_PTR_W'(push_n);
            rd_ptr_reg      <= rd_ptr_reg + RES_PTR_W'(pop);
            count_reg       <= count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ifcs_checker.sv =====
// ----------------------------------------------------------------------------
// IFF form chunk scanner checker
// Port-level properties of the scanner's result stream, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "iff_form_chunk_scanner_defines.svh"

module ifcs_checker
    import ifcs_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,   // [31:0] offset, [63:32] size, [95:64] next
    input wire logic [1:0]  m_tuser,   // [1:0] kind
    input wire logic        m_tlast
);

    logic        stalled;
    logic        end_beat;
    logic        match_beat;
    logic [98:0] beat_bus;
    logic [31:0] next_calc;

    assign stalled    = m_tvalid && !m_tready;
    assign end_beat   = m_tvalid && (m_tuser != KIND_MATCH);
    assign match_beat = m_tvalid && (m_tuser == KIND_MATCH);
    assign beat_bus   = {m_tlast, m_tuser, m_tdata};
    assign next_calc  = m_tdata[31:0] + m_tdata[63:32] + {31'd0, m_tdata[32]};

    `IFCS_ASSERT_NEXT(a_m_hold, aclk, aresetn, stalled, m_tvalid && $stable(beat_bus), "not held")
    `IFCS_ASSERT_NOW(a_end_is_last, aclk, aresetn, end_beat, m_tlast, "ending beat not last")
    `IFCS_ASSERT_NOW(a_end_zero, aclk, aresetn, end_beat, m_tdata == 96'd0, "ending beat has data")
    `IFCS_ASSERT_NOW(a_next_off, aclk, aresetn, match_beat, m_tdata[95:64] == next_calc, "bad next")

endmodule

bind iff_form_chunk_scanner ifcs_checker u_ifcs_checker (.*);

`default_nettype wire

// ===== dv/tb_iff_form_chunk_scanner.sv =====
// ----------------------------------------------------------------------------
// Testbench for the IFF form chunk scanner
// Sends IFF byte streams one beat at a time, some directed and most built at
// random as well-formed forms with random chunks, noise and cut streams. A
// behavioural scanner predicts each result not typed in; the result channel is
// checked field by field in order. Both channels idle at random, and the
// receiver holds off for long stretches so that the scanner stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_iff_form_chunk_scanner;

    import ifcs_pkg::*;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        logic [7:0]  data;
        logic        lst;
        logic        typed;
        kind_t       kind;
    } stim_row_t;

    localparam int DIR_ROWS = 24;

    // Directed rows: register writes, or beats whose result is either typed in
    // here or left to the behavioural scanner.
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h46, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h4F, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h52, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h4D, 1'b0, 1'b1, KIND_NOT_FORM},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'hFF, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h00, 1'b1, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'hA5, 1'b1, 1'b1, KIND_NOT_FORM},
        '{1'b1, CFG_TARGET_TAG,  32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, KIND_MATCH},
        '{1'b1, CFG_FORM_OFFSET, 32'h0000_0000, 8'h00, 1'b0, 1'b0, KIND_MATCH},
        '{1'b1, CFG_DATA_LENGTH, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h46, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h4F, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h52, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h4D, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h00, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h00, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h00, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h08, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h41, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h49, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h46, 1'b0, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h46, 1'b0, 1'b1, KIND_COMPLETE},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h00, 1'b1, 1'b0, KIND_MATCH},
        '{1'b0, CFG_TARGET_TAG,  32'h0000_0000, 8'h46, 1'b1, 1'b1, KIND_NOT_FORM}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_wdata = 32'd0;

    iff_form_chunk_scanner u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Register copies and scan state of the behavioural scanner.
    logic [31:0] tag_cfg;
    logic [31:0] form_off_cfg;
    logic [31:0] data_len_cfg;
    logic [31:0] byte_pos;
    phase_t      scan_ph;
    logic [63:0] hdr_shift;
    logic [31:0] form_limit;
    logic [32:0] skip_left;
    logic        scan_done;

    result_t     step_results[$];
    result_t     expected_results[$];
    logic [7:0]  frame_bytes[$];

    int mismatch_count    = 0;
    int rand_beats        = 0;
    int burst_left        = 0;
    bit offering          = 1'b0;
    bit cfg_on            = 1'b0;
    int hold_req          = 0;
    int hold_seen         = 0;
    int rx_hold           = 0;
    int rx_span           = 0;
    int rx_mode           = 0;

    task automatic clear_scan();
        byte_pos   = 32'd0;
        scan_ph    = PH_FORM_TAG;
        hdr_shift  = 64'd0;
        form_limit = 32'd0;
        skip_left  = 33'd0;
        scan_done  = 1'b0;
    endtask

    task automatic add_result(input kind_t k, input logic [31:0] off,
                              input logic [31:0] size, input logic [31:0] nxt);
        result_t r;
        r.kind              = k;
        r.next_offset       = nxt;
        r.chunk_size        = size;
        r.chunk_data_offset = off;
        r.last_of_run       = 1'b0;
        step_results.push_back(r);
    endtask

    // Advances the scan by one byte and leaves that byte's results in
    // step_results.
    task automatic scan_byte(input logic [7:0] b, input logic lst);
        logic [63:0] here;
        logic [63:0] cdata;
        logic [63:0] csz;
        logic [63:0] fe;
        logic [63:0] nxt;
        step_results.delete();
        if (!scan_done) begin
            here      = {32'd0, form_off_cfg} + {32'd0, byte_pos};
            hdr_shift = {hdr_shift[55:0], b};
            case (scan_ph)
                PH_FORM_TAG: begin
                    if (byte_pos == POS_TAG_END) begin
                        if (hdr_shift[31:0] != TAG_FORM ||
                            {32'd0, form_off_cfg} + 64'(FORM_HDR_BYTES) >
                            {32'd0, data_len_cfg}) begin
                            add_result(KIND_NOT_FORM, 32'd0, 32'd0, 32'd0);
                            scan_done = 1'b1;
                        end else begin
                            scan_ph = PH_FORM_SIZE;
                        end
                    end
                end
                PH_FORM_SIZE: begin
                    if (byte_pos == POS_SIZE_END) begin
                        form_limit = form_off_cfg + 32'd8 + hdr_shift[31:0];
                        if (form_limit > data_len_cfg) form_limit = data_len_cfg;
                        scan_ph = PH_FORM_TYPE;
                    end
                end
                PH_FORM_TYPE: begin
                    if (byte_pos == POS_TYPE_END) begin
                        if ({32'd0, form_off_cfg} + 64'(FORM_HDR_BYTES + CHUNK_HDR_BYTES) >
                            {32'd0, form_limit}) begin
                            add_result(KIND_COMPLETE, 32'd0, 32'd0, 32'd0);
                            scan_done = 1'b1;
                        end else begin
                            scan_ph   = PH_HEADER;
                            skip_left = 33'(CHUNK_HDR_BYTES);
                        end
                    end
                end
                PH_HEADER: begin
                    if (skip_left != 33'd0) skip_left = skip_left - 33'd1;
                    if (skip_left == 33'd0) begin
                        cdata = here + 64'd1;
                        csz   = {32'd0, hdr_shift[31:0]};
                        fe    = {32'd0, form_limit};
                        if (cdata + csz > fe) csz = (fe > cdata) ? fe - cdata : 64'd0;
                        nxt = cdata + csz + {63'd0, csz[0]};
                        if (hdr_shift[63:32] == tag_cfg) begin
                            add_result(KIND_MATCH, cdata[31:0], csz[31:0], nxt[31:0]);
                        end
                        if (nxt + 64'(CHUNK_HDR_BYTES) > fe) begin
                            add_result(KIND_COMPLETE, 32'd0, 32'd0, 32'd0);
                            scan_done = 1'b1;
                        end else if (nxt == cdata) begin
                            skip_left = 33'(CHUNK_HDR_BYTES);
                        end else begin
                            skip_left = nxt[32:0] - cdata[32:0];
                            scan_ph   = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_left != 33'd0) skip_left = skip_left - 33'd1;
                    if (skip_left == 33'd0) begin
                        scan_ph   = PH_HEADER;
                        skip_left = 33'(CHUNK_HDR_BYTES);
                    end
                end
                default: begin
                    scan_done = 1'b1;
                end
            endcase
            byte_pos = byte_pos + 32'd1;
        end
        if (lst) begin
            if (!scan_done) begin
                add_result((scan_ph < PH_HEADER) ? KIND_NOT_FORM : KIND_COMPLETE,
                           32'd0, 32'd0, 32'd0);
            end
            clear_scan();
        end
        if (step_results.size() > 0) step_results[$].last_of_run = 1'b1;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("tb: mismatch on %s at %0t: got %h, expected %h",
                     field, $realtime, got, want);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[31:0] !== want.chunk_data_offset)
                    report_mismatch("chunk_data_offset", m_tdata[31:0],
                                    want.chunk_data_offset);
                if (m_tdata[63:32] !== want.chunk_size)
                    report_mismatch("chunk_size", m_tdata[63:32], want.chunk_size);
                if (m_tdata[95:64] !== want.next_offset)
                    report_mismatch("next_offset", m_tdata[95:64], want.next_offset);
                if (m_tlast !== want.last_of_run)
                    report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last_of_run));
            end
        end
    end

    // The receiver changes its stall pattern at the end of each span of random
    // length and holds off completely for a long stretch whenever the stimulus asks for it.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rx_hold   = 300;
            m_tready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_span = $urandom_range(10, 60);
                rx_mode = $urandom_range(0, 3);
            end
            rx_span = rx_span - 1;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 2) == 0);
                default: m_tready <= rx_span[0];
            endcase
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic lst,
                             input logic typed, input kind_t k);
        result_t r;
        if (cfg_on) begin
            cfg_wr_en <= 1'b0;
            cfg_on = 1'b0;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        scan_byte(b, lst);
        if (typed) begin
            r.kind              = k;
            r.next_offset       = 32'd0;
            r.chunk_size        = 32'd0;
            r.chunk_data_offset = 32'd0;
            r.last_of_run       = 1'b1;
            expected_results.push_back(r);
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
    endtask

    task automatic sender_pause();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic stop_sending();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic wait_drained();
        stop_sending();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_on = 1'b1;
        @(posedge aclk);
        case (idx)
            CFG_TARGET_TAG:  tag_cfg      = val;
            CFG_FORM_OFFSET: form_off_cfg = val;
            CFG_DATA_LENGTH: data_len_cfg = val;
            default: ;
        endcase
    endtask

    task automatic put_be32(input logic [31:0] v);
        for (int k = 3; k >= 0; k--) frame_bytes.push_back(v[8*k +: 8]);
    endtask

    function automatic logic [31:0] pick_tag();
        case ($urandom_range(0, 4))
            0, 1: return tag_cfg;
            2: return TAG_FORM;
            default: return $urandom;
        endcase
    endfunction

    // Builds one stream: mostly a form with random chunks, sometimes noise,
    // sometimes cut short or followed by stray bytes.
    task automatic build_frame();
        int          nchunks;
        int          fill;
        int          keep;
        logic [31:0] tags[4];
        logic [31:0] sizes[4];
        logic [31:0] body;
        logic [31:0] fsize;
        frame_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 16)) frame_bytes.push_back(8'($urandom));
            return;
        end
        nchunks = $urandom_range(0, 4);
        body    = 32'd4;
        for (int c = 0; c < nchunks; c++) begin
            tags[c]  = pick_tag();
            sizes[c] = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 9);
            body     = body + 32'd8 + sizes[c] + {31'd0, sizes[c][0]};
        end
        case ($urandom_range(0, 7))
            0: fsize = $urandom;
            1: fsize = body - $urandom_range(1, 12);
            default: fsize = body;
        endcase
        put_be32(TAG_FORM);
        if ($urandom_range(0, 11) == 0)
            frame_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        put_be32(fsize);
        put_be32($urandom);
        for (int c = 0; c < nchunks; c++) begin
            put_be32(tags[c]);
            put_be32(sizes[c]);
            fill = (sizes[c] > 32'd12) ? $urandom_range(0, 12)
                                       : int'(sizes[c]) + int'(sizes[c][0]);
            repeat (fill) frame_bytes.push_back(8'($urandom));
        end
        case ($urandom_range(0, 5))
            0: begin
                keep = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            end
            1: repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic send_frame(input bit keep_open);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_beat(frame_bytes[i], (i == frame_bytes.size() - 1) && !keep_open,
                      1'b0, KIND_MATCH);
            sender_pause();
            rand_beats++;
        end
    endtask

    task automatic pick_config(input int n);
        logic [31:0] t;
        logic [31:0] fo;
        logic [31:0] dl;
        t = $urandom;
        case (n % 6)
            0: begin
                fo = 32'd0;
                dl = 32'hFFFF_FFFF;
            end
            1: begin
                fo = 32'hFFFF_FFF0;
                dl = 32'hFFFF_FFFF;
            end
            2: begin
                fo = $urandom;
                dl = (fo > 32'hFFFF_FF87) ? 32'hFFFF_FFFF : fo + $urandom_range(12, 120);
            end
            3: begin
                fo = $urandom_range(0, 255);
                dl = fo + $urandom_range(0, 48);
            end
            4: begin
                t  = 32'h0000_0000;
                fo = 32'hFFFF_FFFF;
                dl = 32'hFFFF_FFFF;
            end
            default: begin
                t  = 32'hFFFF_FFFF;
                fo = $urandom_range(0, 4096);
                dl = $urandom;
            end
        endcase
        write_reg(CFG_TARGET_TAG, t);
        write_reg(CFG_FORM_OFFSET, fo);
        write_reg(CFG_DATA_LENGTH, dl);
    endtask

    initial begin
        int phase_idx;
        int nframes;
        tag_cfg      = 32'd0;
        form_off_cfg = 32'd0;
        data_len_cfg = 32'd0;
        clear_scan();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].is_cfg) begin
                if (!cfg_on) wait_drained();
                write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].val);
            end else begin
                send_beat(DIR_TABLE[i].data, DIR_TABLE[i].lst,
                          DIR_TABLE[i].typed, DIR_TABLE[i].kind);
                sender_pause();
            end
        end

        phase_idx = 0;
        while (rand_beats < 550) begin
            wait_drained();
            pick_config(phase_idx);
            nframes = (phase_idx % 6 == 4) ? 1 :
                      (phase_idx % 3 == 1) ? 5 : $urandom_range(2, 6);
            for (int f = 0; f < nframes; f++) begin
                if (f == 1 && phase_idx % 3 == 1) hold_req++;
                build_frame();
                send_frame(f == nframes - 1 && $urandom_range(0, 4) == 0);
            end
            phase_idx++;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ifcs_pkg.sv
rtl/iff_form_chunk_scanner.sv
rtl/ifcs_checker.sv
dv/tb_iff_form_chunk_scanner.sv
